[rtl/ptdt_pkg.sv]
// Shared types and constants for the per-key timestamp delta tracker.
// Depends on nothing; imported by ptdt_table and the top level.
`timescale 1ns / 1ps

package ptdt_pkg;

	// Timestamp width in microseconds
	localparam int TIME_W = 48;

	// Key is {terminal, subaddress, direction}
	localparam int KEY_W     = 11;
	localparam int KEY_COUNT = 1 << KEY_W;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [KEY_W-1:0]  key_t;

	localparam key_t KEY_LAST = key_t'(KEY_COUNT - 1);

	// One table entry: flags and last stored time
	typedef struct packed {
		logic  warned;
		logic  seen;
		time_t last;
	} entry_t;

	typedef enum logic [2:0] {
		OUT_NO_KEY       = 3'd0,
		OUT_UNCALIBRATED = 3'd1,
		OUT_FIRST        = 3'd2,
		OUT_ELAPSED      = 3'd3,
		OUT_BACKWARD     = 3'd4
	} outcome_t;

endpackage

[rtl/ptdt_table.sv]
// Keyed state table: one synchronous memory of entry_t with a clearing sweep.
// Depends on ptdt_pkg.
`timescale 1ns / 1ps

module ptdt_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  ptdt_pkg::key_t   rd_key,
	output ptdt_pkg::entry_t rd_data,
	input  logic             wr_en,
	input  ptdt_pkg::key_t   wr_key,
	input  ptdt_pkg::entry_t wr_data,
	output logic             busy
);
	import ptdt_pkg::*;

	entry_t mem [KEY_COUNT];

	logic clr_q;
	key_t clr_idx_q;

	// Sweep every entry to zero after reset, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == KEY_LAST) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_key] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_key];
		end
	end

	assign busy = clr_q;

endmodule

[rtl/per_key_timestamp_delta_tracker_unit.sv]
// Top level of the per-key timestamp delta tracker.
// Depends on ptdt_pkg and ptdt_table.
`timescale 1ns / 1ps

// Takes one bus command record per beat and returns one result beat for it.
// After reset the block sweeps its 2048-entry table with in_ready low; after
// that it accepts one record per cycle while out_ready stays high. A record
// reads its table entry at acceptance, is resolved from the stage 1 registers
// and lands in the output register. The entry of a timed record is written
// back as the result is registered, and a record that follows on the
// same key takes the written value through a forwarding register. Throughput
// is set by the single read-modify-write of the table: one record per cycle
// while out_ready stays high.
module per_key_timestamp_delta_tracker_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       has_command,
	input  logic                       time_valid,
	input  logic [4:0]                 terminal,
	input  logic [4:0]                 subaddress,
	input  logic                       transmit,
	input  ptdt_pkg::time_t            time_us,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 outcome,
	output ptdt_pkg::time_t            elapsed_us,
	output ptdt_pkg::time_t            prev_time,
	output ptdt_pkg::time_t            curr_time,
	output ptdt_pkg::key_t             key_out,
	output logic                       first_warning
);
	import ptdt_pkg::*;

	logic   accept;
	logic   busy;
	key_t   key_in;
	entry_t rd_data;

	// Stage 1 registers
	logic   valid_s1;
	logic   has_cmd_s1;
	logic   time_ok_s1;
	key_t   key_s1;
	time_t  time_s1;
	logic   fwd_hit_s1;
	entry_t fwd_data_s1;

	// Output registers
	logic     out_valid_q;
	outcome_t outcome_q;
	time_t    elapsed_q;
	time_t    prev_q;
	time_t    curr_q;
	key_t     key_q;
	logic     warn_q;

	// Resolve logic
	entry_t   old_entry;
	entry_t   wr_data;
	logic     timed;
	logic     backward;
	logic     adv;
	logic     wr_en;
	outcome_t res_outcome;
	time_t    diff;

	assign key_in = {terminal, subaddress, transmit};
	assign adv    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !busy && (!valid_s1 || adv);
	assign accept = in_valid && in_ready;

	ptdt_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_key  (key_in),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_key  (key_s1),
		.wr_data (wr_data),
		.busy    (busy)
	);

	// Pick the freshest entry, classify and build the write-back
	always_comb begin
		old_entry = fwd_hit_s1 ? fwd_data_s1 : rd_data;
		timed     = has_cmd_s1 && time_ok_s1;
		backward  = old_entry.seen && (time_s1 < old_entry.last);
		diff      = time_s1 - old_entry.last;
		if (!has_cmd_s1) begin
			res_outcome = OUT_NO_KEY;
		end else if (!time_ok_s1) begin
			res_outcome = OUT_UNCALIBRATED;
		end else if (!old_entry.seen) begin
			res_outcome = OUT_FIRST;
		end else if (backward) begin
			res_outcome = OUT_BACKWARD;
		end else begin
			res_outcome = OUT_ELAPSED;
		end
		wr_en          = adv && timed;
		wr_data.warned = old_entry.warned || backward;
		wr_data.seen   = 1'b1;
		wr_data.last   = time_s1;
	end

	// Stage 1 and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv);
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the accepted beat and any same-key write-back
	always_ff @(posedge clk) begin
		if (accept) begin
			has_cmd_s1  <= has_command;
			time_ok_s1  <= time_valid;
			key_s1      <= key_in;
			time_s1     <= time_us;
			fwd_hit_s1  <= wr_en && (key_s1 == key_in);
			fwd_data_s1 <= wr_data;
		end
	end

	// Load the result beat, zeroing fields that the outcome leaves unused
	always_ff @(posedge clk) begin
		if (adv) begin
			outcome_q <= res_outcome;
			elapsed_q <= (res_outcome == OUT_ELAPSED) ? diff : '0;
			prev_q    <= (res_outcome == OUT_BACKWARD) ? old_entry.last : '0;
			curr_q    <= (res_outcome == OUT_BACKWARD) ? time_s1 : '0;
			key_q     <= (res_outcome == OUT_BACKWARD) ? key_s1 : '0;
			warn_q    <= (res_outcome == OUT_BACKWARD) && !old_entry.warned;
		end
	end

	assign out_valid     = out_valid_q;
	assign outcome       = outcome_q;
	assign elapsed_us    = elapsed_q;
	assign prev_time     = prev_q;
	assign curr_time     = curr_q;
	assign key_out       = key_q;
	assign first_warning = warn_q;

endmodule

[test/ptdt_checker.sv]
// Scoreboard for the per-key timestamp delta tracker: predicts every result beat
// and compares it with the block's output. Depends on ptdt_pkg.
`timescale 1ns / 1ps

module ptdt_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              has_command,
	input  logic              time_valid,
	input  logic [4:0]        terminal,
	input  logic [4:0]        subaddress,
	input  logic              transmit,
	input  ptdt_pkg::time_t   time_us,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [2:0]        outcome,
	input  ptdt_pkg::time_t   elapsed_us,
	input  ptdt_pkg::time_t   prev_time,
	input  ptdt_pkg::time_t   curr_time,
	input  ptdt_pkg::key_t    key_out,
	input  logic              first_warning,
	output int                failures,
	output int                pending
);
	import ptdt_pkg::*;

	typedef struct {
		outcome_t outcome;
		time_t    elapsed;
		time_t    prev;
		time_t    curr;
		key_t     key;
		logic     warn;
	} delta_result_t;

	// Own copy of the keyed table
	time_t last_stamp [KEY_COUNT];
	bit    key_seen   [KEY_COUNT];
	bit    key_warned [KEY_COUNT];

	delta_result_t pending_results [$];

	// Resolve one record against the table and update the entry
	function automatic delta_result_t resolve_record(input logic cmd, input logic tv,
			input logic [4:0] rt, input logic [4:0] sa, input logic tx, input time_t t);
		delta_result_t r;
		key_t          k;
		time_t         old;
		r = '{OUT_NO_KEY, '0, '0, '0, '0, 1'b0};
		k = {rt, sa, tx};
		if (!cmd) begin
			r.outcome = OUT_NO_KEY;
		end else if (!tv) begin
			r.outcome = OUT_UNCALIBRATED;
		end else begin
			old = last_stamp[k];
			if (!key_seen[k]) begin
				r.outcome = OUT_FIRST;
			end else if (t >= old) begin
				r.outcome = OUT_ELAPSED;
				r.elapsed = t - old;
			end else begin
				r.outcome = OUT_BACKWARD;
				r.prev    = old;
				r.curr    = t;
				r.key     = k;
				r.warn    = !key_warned[k];
				key_warned[k] = 1'b1;
			end
			// The stored time is replaced on every timed record
			last_stamp[k] = t;
			key_seen[k]   = 1'b1;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			failures++;
		end
	endtask

	// Compare result beats, then predict accepted records
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				key_seen[k]   = 1'b0;
				key_warned[k] = 1'b0;
				last_stamp[k] = '0;
			end
			pending_results.delete();
			failures = 0;
			pending  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result beat, outcome %0d", outcome);
					failures++;
				end else begin
					delta_result_t w;
					w = pending_results.pop_front();
					check_field("outcome", 64'(w.outcome), 64'(outcome));
					check_field("elapsed_us", 64'(w.elapsed), 64'(elapsed_us));
					check_field("prev_time", 64'(w.prev), 64'(prev_time));
					check_field("curr_time", 64'(w.curr), 64'(curr_time));
					check_field("key_out", 64'(w.key), 64'(key_out));
					check_field("first_warning", 64'(w.warn), 64'(first_warning));
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(resolve_record(has_command, time_valid,
					terminal, subaddress, transmit, time_us));
			pending = pending_results.size();
		end
	end

endmodule

[test/per_key_timestamp_delta_tracker_unit_tb.sv]
// Testbench top for the per-key timestamp delta tracker: drives records and
// result back-pressure, gives the verdict. Depends on ptdt_pkg and ptdt_checker.
`timescale 1ns / 1ps

module per_key_timestamp_delta_tracker_unit_tb;
	import ptdt_pkg::*;

	localparam int    RANDOM_RECORDS = 850;
	localparam int    HOLD_CYCLES    = 400;
	localparam time_t TIME_MAX       = '1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        has_command;
	logic        time_valid;
	logic [4:0]  terminal;
	logic [4:0]  subaddress;
	logic        transmit;
	time_t       time_us;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  outcome;
	time_t       elapsed_us;
	time_t       prev_time;
	time_t       curr_time;
	key_t        key_out;
	logic        first_warning;
	int          failures;
	int          pending;

	bit idle_on;
	bit hold_req;
	bit hold_done;

	// Small pool of busy keys so that most records hit a key seen before
	logic [4:0] pool_rt [6];
	logic [4:0] pool_sa [6];
	logic       pool_tx [6];
	time_t      pool_now [6];

	per_key_timestamp_delta_tracker_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.has_command(has_command), .time_valid(time_valid),
		.terminal(terminal), .subaddress(subaddress), .transmit(transmit),
		.time_us(time_us),
		.out_valid(out_valid), .out_ready(out_ready),
		.outcome(outcome), .elapsed_us(elapsed_us), .prev_time(prev_time),
		.curr_time(curr_time), .key_out(key_out), .first_warning(first_warning)
	);

	ptdt_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.has_command(has_command), .time_valid(time_valid),
		.terminal(terminal), .subaddress(subaddress), .transmit(transmit),
		.time_us(time_us),
		.out_valid(out_valid), .out_ready(out_ready),
		.outcome(outcome), .elapsed_us(elapsed_us), .prev_time(prev_time),
		.curr_time(curr_time), .key_out(key_out), .first_warning(first_warning),
		.failures(failures), .pending(pending)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Give up well past the slowest correct run
	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Offer one record and hold it until its beat is taken
	task automatic offer_record(input logic cmd, input logic tv, input logic [4:0] rt,
			input logic [4:0] sa, input logic tx, input time_t t);
		logic taken;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		has_command <= cmd;
		time_valid  <= tv;
		terminal    <= rt;
		subaddress  <= sa;
		transmit    <= tx;
		time_us     <= t;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Result side: random stalls, plus one long hold-off to back the block up
	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Record side
	initial begin
		int         p;
		int         pick;
		logic       cmd;
		logic       tv;
		logic [4:0] rt;
		logic [4:0] sa;
		logic       tx;
		time_t      t;

		in_valid    <= 1'b0;
		has_command <= 1'b0;
		time_valid  <= 1'b0;
		terminal    <= '0;
		subaddress  <= '0;
		transmit    <= 1'b0;
		time_us     <= '0;
		idle_on   = 1'b0;
		hold_req  = 1'b0;
		hold_done = 1'b0;
		for (int i = 0; i < 6; i++) begin
			pool_rt[i]  = 5'($urandom);
			pool_sa[i]  = 5'($urandom);
			pool_tx[i]  = 1'($urandom);
			pool_now[i] = time_t'($urandom_range(0, 1000));
		end
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		// Directed: no key, uncalibrated, first, equal, backward with and without warning
		offer_record(1'b0, 1'b0, 5'd0, 5'd0, 1'b0, '0);
		offer_record(1'b0, 1'b1, 5'd31, 5'd31, 1'b1, TIME_MAX);
		offer_record(1'b1, 1'b0, 5'd31, 5'd31, 1'b1, TIME_MAX);
		offer_record(1'b1, 1'b1, 5'd31, 5'd31, 1'b1, TIME_MAX);
		offer_record(1'b1, 1'b1, 5'd31, 5'd31, 1'b1, TIME_MAX);
		offer_record(1'b1, 1'b1, 5'd31, 5'd31, 1'b1, '0);
		offer_record(1'b1, 1'b1, 5'd31, 5'd31, 1'b1, 48'd5);
		offer_record(1'b1, 1'b1, 5'd31, 5'd31, 1'b1, 48'd3);
		offer_record(1'b1, 1'b1, 5'd0, 5'd0, 1'b0, '0);
		offer_record(1'b1, 1'b1, 5'd0, 5'd0, 1'b0, TIME_MAX);
		offer_record(1'b1, 1'b0, 5'd0, 5'd0, 1'b0, 48'd7);
		offer_record(1'b1, 1'b1, 5'd0, 5'd0, 1'b0, TIME_MAX - 1);
		offer_record(1'b1, 1'b1, 5'd0, 5'd0, 1'b1, 48'd100);
		offer_record(1'b1, 1'b1, 5'd0, 5'd1, 1'b0, 48'd50);
		offer_record(1'b1, 1'b1, 5'd0, 5'd0, 1'b1, 48'd100);
		offer_record(1'b1, 1'b1, 5'd16, 5'd8, 1'b1, 48'h8000_0000_0000);
		offer_record(1'b1, 1'b1, 5'd16, 5'd8, 1'b1, 48'h7FFF_FFFF_FFFF);
		offer_record(1'b1, 1'b1, 5'd16, 5'd8, 1'b1, '0);
		offer_record(1'b0, 1'b0, 5'd16, 5'd8, 1'b1, 48'h5555_5555_5555);
		offer_record(1'b1, 1'b1, 5'd16, 5'd8, 1'b1, 48'hAAAA_AAAA_AAAA);

		// Random: mostly timed records on busy keys, some noise
		idle_on = 1'b1;
		for (int n = 0; n < RANDOM_RECORDS; n++) begin
			if (n == 300)
				hold_req = 1'b1;
			if (n == RANDOM_RECORDS - 150)
				idle_on = 1'b0;
			cmd  = 1'b1;
			tv   = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				cmd = 1'b0;
			else if (pick < 10)
				tv = 1'b0;
			p = -1;
			if ($urandom_range(0, 9) < 7) begin
				p  = $urandom_range(0, 5);
				rt = pool_rt[p];
				sa = pool_sa[p];
				tx = pool_tx[p];
			end else begin
				rt = 5'($urandom);
				sa = 5'($urandom);
				tx = 1'($urandom);
			end
			pick = $urandom_range(0, 9);
			if (p < 0 || pick == 0)
				t = time_t'({$urandom, $urandom});
			else if (pick == 1)
				t = pool_now[p];
			else if (pick == 2)
				t = pool_now[p] - time_t'($urandom_range(1, 1000));
			else
				t = pool_now[p] + time_t'($urandom_range(0, 1000));
			// Advance the key's clock only when the record will be stored
			if (p >= 0 && cmd && tv)
				pool_now[p] = t;
			offer_record(cmd, tv, rt, sa, tx, t);
		end
		in_valid <= 1'b0;

		// Drain, then wait for any stray beat before the verdict
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
